// ===== design/ctp_pkg.sv =====
// Shared constants, opcodes and types for the countdown timer pool.
package ctp_pkg;

    localparam logic [15:0] FREE_MARK   = 16'hFFFF;
    localparam logic [6:0]  FIRST_ALLOC = 7'd2;
    localparam logic [15:0] TPS_RESET   = 16'd1000;
    localparam logic [0:0]  REG_TPS     = 1'b0;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_ARM   = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] delay;
        logic [5:0]  slot_id;
        logic        found;
    } t_scan_ctl;

    typedef struct packed {
        logic alloc;
        logic read_hit;
    } t_scan_res;

    function automatic logic [15:0] clamp_delay(input logic [15:0] d);
        logic [15:0] v;
        v = (d == FREE_MARK) ? (FREE_MARK - 16'd1) : d;
        return v;
    endfunction

endpackage

// ===== design/ctp_cell.sv =====
// One slot cell of the rotating chain; it takes its neighbor's count on each scan step.
module ctp_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_shift,
    input  logic [15:0] i_count,
    output logic [15:0] o_count
);

    logic [15:0] r_count;
    logic [15:0] n_count;

    always_comb begin
        n_count = i_shift ? i_count : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ctp_pkg::FREE_MARK;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ===== design/ctp_head.sv =====
// Update logic applied to the slot at the head of the chain during a scan.
module ctp_head #(
    parameter int IDX_W = 3
) (
    input  logic [IDX_W-1:0]    i_idx,
    input  ctp_pkg::t_scan_ctl  i_ctl,
    input  logic [15:0]         i_count,
    output logic [15:0]         o_count,
    output ctp_pkg::t_scan_res  o_res
);

    logic [6:0] idx7;
    logic       id_match;

    always_comb begin
        idx7     = 7'(i_idx);
        id_match = (7'(i_ctl.slot_id) == idx7);
        o_count  = i_count;
        o_res    = '0;
        case (i_ctl.op)
            ctp_pkg::OP_TICK: begin
                if (i_count != 16'd0 && i_count != ctp_pkg::FREE_MARK) begin
                    o_count = i_count - 16'd1;
                end
            end
            ctp_pkg::OP_START: begin
                if (!i_ctl.found && idx7 >= ctp_pkg::FIRST_ALLOC &&
                    i_count == ctp_pkg::FREE_MARK) begin
                    o_count     = ctp_pkg::clamp_delay(i_ctl.delay);
                    o_res.alloc = 1'b1;
                end
            end
            ctp_pkg::OP_STOP: begin
                if (id_match && idx7 >= ctp_pkg::FIRST_ALLOC) begin
                    o_count = ctp_pkg::FREE_MARK;
                end
            end
            ctp_pkg::OP_READ: begin
                o_res.read_hit = id_match;
            end
            ctp_pkg::OP_ARM: begin
                if (idx7 == 7'd0) begin
                    o_count = ctp_pkg::clamp_delay(i_ctl.delay);
                end
            end
            default: begin
                o_count = i_count;
            end
        endcase
    end

endmodule

// ===== design/countdown_timer_pool_core.sv =====
// Top level of the countdown timer pool: slot chain, scan control, totals and APB register.
// Each word is accepted only while the block is idle, and its scan takes one step per slot as the
// slot chain rotates once past the head update logic; the result is registered at the last step,
// which waits while a previous result is still unaccepted, and a new word is accepted only after
// the scan of the last one has finished.
// Synchronous active-low reset frees every slot, clears the totals and loads 1000 ticks/second.
module countdown_timer_pool_core #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_delay,
    input  logic [5:0]  i_slot_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_slot_result,
    output logic [15:0] o_count_value,
    output logic [31:0] o_seconds_total,
    output logic [31:0] o_ticks_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    logic [15:0] w_count [SLOT_COUNT];
    logic [15:0] w_head_count;
    ctp_pkg::t_scan_ctl w_ctl;
    ctp_pkg::t_scan_res w_res;

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [2:0]       r_op;
    logic [15:0]      r_delay;
    logic [5:0]       r_slot_id;
    logic             r_found;
    logic [6:0]       r_slot_acc;
    logic [15:0]      r_count_acc;
    logic             r_out_valid;
    logic [6:0]       r_out_slot;
    logic [15:0]      r_out_count;
    logic [31:0]      r_out_secs;
    logic [31:0]      r_out_ticks;
    logic [15:0]      r_tps;
    logic [15:0]      r_sec_cd;
    logic [31:0]      r_secs;
    logic [31:0]      r_ticks;

    logic        w_last;
    logic        w_step;
    logic        w_fire;
    logic [6:0]  n_slot_acc;
    logic [15:0] n_count_acc;

    assign w_ctl.op      = r_op;
    assign w_ctl.delay   = r_delay;
    assign w_ctl.slot_id = r_slot_id;
    assign w_ctl.found   = r_found;

    ctp_head #(
        .IDX_W (IDX_W)
    ) u_head (
        .i_idx   (r_idx),
        .i_ctl   (w_ctl),
        .i_count (w_count[0]),
        .o_count (w_head_count),
        .o_res   (w_res)
    );

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        if (g == SLOT_COUNT - 1) begin : g_tail
            ctp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_count (w_head_count),
                .o_count (w_count[g])
            );
        end else begin : g_body
            ctp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_count (w_count[g+1]),
                .o_count (w_count[g])
            );
        end
    end

    assign w_last = (r_idx == LAST_IDX);
    assign w_step = r_busy && (!w_last || !r_out_valid || i_out_ready);
    assign w_fire = i_in_valid && !r_busy;

    always_comb begin
        n_slot_acc  = w_res.alloc ? 7'(r_idx) : r_slot_acc;
        n_count_acc = w_res.read_hit ? w_count[0] : r_count_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_tps       <= ctp_pkg::TPS_RESET;
            r_sec_cd    <= ctp_pkg::TPS_RESET;
            r_secs      <= '0;
            r_ticks     <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == ctp_pkg::REG_TPS) begin
                r_tps <= pwdata[15:0];
            end
            if (w_fire) begin
                r_busy  <= 1'b1;
                r_idx   <= '0;
                r_found <= 1'b0;
                if (i_opcode == ctp_pkg::OP_TICK) begin
                    r_ticks <= r_ticks + 32'd1;
                    if (r_sec_cd <= 16'd1) begin
                        r_secs   <= r_secs + 32'd1;
                        r_sec_cd <= r_tps;
                    end else begin
                        r_sec_cd <= r_sec_cd - 16'd1;
                    end
                end
            end else if (w_step) begin
                if (w_res.alloc) begin
                    r_found <= 1'b1;
                end
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (w_step && w_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_op        <= i_opcode;
            r_delay     <= i_delay;
            r_slot_id   <= i_slot_id;
            r_slot_acc  <= (i_opcode == ctp_pkg::OP_START) ? 7'(SLOT_COUNT) : 7'd0;
            r_count_acc <= '0;
        end else if (w_step) begin
            r_slot_acc  <= n_slot_acc;
            r_count_acc <= n_count_acc;
        end
        if (w_step && w_last) begin
            r_out_slot  <= n_slot_acc;
            r_out_count <= n_count_acc;
            r_out_secs  <= r_secs;
            r_out_ticks <= r_ticks;
        end
    end

    assign o_in_ready      = !r_busy;
    assign o_out_valid     = r_out_valid;
    assign o_slot_result   = r_out_slot;
    assign o_count_value   = r_out_count;
    assign o_seconds_total = r_out_secs;
    assign o_ticks_total   = r_out_ticks;
    assign prdata          = (paddr[2] == ctp_pkg::REG_TPS) ? {16'd0, r_tps} : 32'd0;
    assign pready          = 1'b1;

endmodule
